@@ rtl/core/ipd_pkg.sv @@
// Package with the packet layout, header codes and status codes of the IMU FIFO decoder.
package ipd_pkg;

    localparam int PKT_LEN        = 20;
    localparam int EMPTY_FILL_LEN = 8;
    localparam int POS_W          = 5;

    localparam logic [7:0] HDR_SAMPLE   = 8'h78;
    localparam logic [7:0] EMPTY_FILL   = 8'h7F;
    localparam logic [7:0] MARKER_HIGH  = 8'h80;
    localparam logic [7:0] MARKER_LOW   = 8'h00;
    localparam logic [7:0] HIGH_NIBBLE  = 8'hF0;
    localparam logic [7:0] LOW_NIBBLE   = 8'h0F;

    typedef logic [PKT_LEN-1:0][7:0] packet_t;

    typedef enum logic [2:0] {
        ST_SAMPLE   = 3'd0,
        ST_UNSYNCED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_CORRUPT  = 3'd3,
        ST_NO_VALID = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [19:0] accel_x;
        logic signed [19:0] accel_y;
        logic signed [19:0] accel_z;
        logic signed [19:0] gyro_x;
        logic signed [19:0] gyro_y;
        logic signed [19:0] gyro_z;
        logic               accel_ok;
        logic               gyro_ok;
        status_t            status;
        logic               restart;
    } result_t;

endpackage

@@ rtl/core/ipd_assembler.sv @@
// Gathers FIFO words into 20-byte packets and holds each complete packet in a register.
module ipd_assembler
    import ipd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] fifo_byte,
    output logic       pkt_valid,
    input  logic       pkt_ready,
    output packet_t    pkt_data
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PKT_LEN - 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             pkt_valid_reg;
    logic             pkt_valid_next;
    logic [7:0]       buf_reg [PKT_LEN-1];
    packet_t          pkt_reg;
    packet_t          pkt_next;
    logic             accept;
    logic             last_word;

    assign last_word = (pos_reg == LAST_POS);
    assign in_ready  = !last_word || !pkt_valid_reg || pkt_ready;
    assign accept    = in_valid && in_ready;
    assign pkt_valid = pkt_valid_reg;
    assign pkt_data  = pkt_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        pkt_valid_next = pkt_valid_reg && !pkt_ready;
        if (accept)
        begin
            if (last_word)
            begin
                pos_next       = '0;
                pkt_valid_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        for (int i = 0; i < PKT_LEN - 1; i++)
        begin
            pkt_next[i] = buf_reg[i];
        end
        pkt_next[PKT_LEN-1] = fifo_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !last_word)
        begin
            buf_reg[pos_reg] <= fifo_byte;
        end
        if (accept && last_word)
        begin
            pkt_reg <= pkt_next;
        end
    end

endmodule

@@ rtl/core/ipd_decoder.sv @@
// Classifies a complete packet, extracts the samples and registers one result word.
module ipd_decoder
    import ipd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pkt_valid,
    output logic    pkt_ready,
    input  packet_t pkt_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    logic    out_valid_reg;
    logic    primed_reg;
    logic    primed_next;
    result_t result_reg;
    result_t result_next;
    logic    take;
    logic    accel_good;
    logic    gyro_good;
    logic    empty_pkt;
    logic [19:0] accel_v [3];
    logic [19:0] gyro_v [3];

    assign take      = !out_valid_reg || out_ready;
    assign pkt_ready = take;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        accel_good = !(pkt_data[1] == MARKER_HIGH && pkt_data[2] == MARKER_LOW &&
                       pkt_data[3] == MARKER_HIGH && pkt_data[4] == MARKER_LOW &&
                       pkt_data[5] == MARKER_HIGH && pkt_data[6] == MARKER_LOW);
        gyro_good  = !(pkt_data[7] == MARKER_HIGH && pkt_data[8] == MARKER_LOW &&
                       pkt_data[9] == MARKER_HIGH && pkt_data[10] == MARKER_LOW &&
                       pkt_data[11] == MARKER_HIGH && pkt_data[12] == MARKER_LOW);
        empty_pkt = 1'b1;
        for (int i = 0; i < PKT_LEN; i++)
        begin
            if (pkt_data[i] != ((i < EMPTY_FILL_LEN) ? EMPTY_FILL : 8'h00))
            begin
                empty_pkt = 1'b0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            accel_v[i] = {pkt_data[1+2*i], pkt_data[2+2*i],
                          4'((pkt_data[17+i] & HIGH_NIBBLE) >> 4)};
            gyro_v[i]  = {pkt_data[7+2*i], pkt_data[8+2*i],
                          4'(pkt_data[17+i] & LOW_NIBBLE)};
        end

        result_next = '0;
        primed_next = primed_reg;
        if (pkt_data[0] == HDR_SAMPLE)
        begin
            primed_next = 1'b1;
            if (!accel_good && !gyro_good)
            begin
                result_next.status = ST_NO_VALID;
            end
            else
            begin
                result_next.status   = ST_SAMPLE;
                result_next.accel_ok = accel_good;
                result_next.gyro_ok  = gyro_good;
                if (accel_good)
                begin
                    result_next.accel_x = accel_v[0];
                    result_next.accel_y = accel_v[1];
                    result_next.accel_z = accel_v[2];
                end
                if (gyro_good)
                begin
                    result_next.gyro_x = gyro_v[0];
                    result_next.gyro_y = gyro_v[1];
                    result_next.gyro_z = gyro_v[2];
                end
            end
        end
        else if (!primed_reg)
        begin
            result_next.status = ST_UNSYNCED;
        end
        else if (empty_pkt)
        begin
            result_next.status = ST_EMPTY;
        end
        else
        begin
            primed_next         = 1'b0;
            result_next.status  = ST_CORRUPT;
            result_next.restart = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= pkt_valid;
            end
            if (take && pkt_valid)
            begin
                primed_reg <= primed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && pkt_valid)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/core/imu_fifo_packet_decoder_core.sv @@
// Top level of the IMU FIFO packet decoder.
// The block takes one FIFO word per cycle and emits one result for every 20th word,
// classifying the packet and decoding three 20-bit accel and gyro samples. A
// packet passes through two registers, the packet register and the result
// register, before its result is presented. Throughput is one word per cycle;
// in_ready drops only at the last word of a packet, when a complete packet and
// a result are both held while out_ready is low.
module imu_fifo_packet_decoder_core
    import ipd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         fifo_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] accel_x,
    output logic signed [19:0] accel_y,
    output logic signed [19:0] accel_z,
    output logic signed [19:0] gyro_x,
    output logic signed [19:0] gyro_y,
    output logic signed [19:0] gyro_z,
    output logic               accel_ok,
    output logic               gyro_ok,
    output logic [2:0]         packet_status,
    output logic               restart_request
);

    logic    pkt_valid;
    logic    pkt_ready;
    packet_t pkt_data;
    result_t result;

    ipd_assembler u_assembler (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fifo_byte (fifo_byte),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt_data  (pkt_data)
    );

    ipd_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt_data  (pkt_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign accel_x         = result.accel_x;
    assign accel_y         = result.accel_y;
    assign accel_z         = result.accel_z;
    assign gyro_x          = result.gyro_x;
    assign gyro_y          = result.gyro_y;
    assign gyro_z          = result.gyro_z;
    assign accel_ok        = result.accel_ok;
    assign gyro_ok         = result.gyro_ok;
    assign packet_status   = result.status;
    assign restart_request = result.restart;

endmodule

@@ rtl/core/ipd_checker.sv @@
// Port-level checker for the IMU FIFO packet decoder and its bind statement.
module ipd_checker
    import ipd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [19:0] accel_x,
    input logic signed [19:0] accel_y,
    input logic signed [19:0] accel_z,
    input logic signed [19:0] gyro_x,
    input logic signed [19:0] gyro_y,
    input logic signed [19:0] gyro_z,
    input logic               accel_ok,
    input logic               gyro_ok,
    input logic [2:0]         packet_status,
    input logic               restart_request
);

    a_restart_only_on_corrupt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && restart_request |-> packet_status == ST_CORRUPT)
        else $error("restart request without corruption status");

    a_accel_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accel_ok |-> accel_x == 0 && accel_y == 0 && accel_z == 0)
        else $error("accel values nonzero while accel invalid");

    a_gyro_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !gyro_ok |-> gyro_x == 0 && gyro_y == 0 && gyro_z == 0)
        else $error("gyro values nonzero while gyro invalid");

    a_ok_only_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_status != ST_SAMPLE |-> !accel_ok && !gyro_ok)
        else $error("channel flagged valid on a non-sample packet");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packet_status) && $stable(accel_x))
        else $error("result changed while stalled");

endmodule

bind imu_fifo_packet_decoder_core ipd_checker u_ipd_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the IMU FIFO packet decoder: directed and random FIFO streams.
module tb_top;
    import ipd_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         fifo_byte;
    logic               out_valid;
    logic               out_ready;
    logic signed [19:0] accel_x;
    logic signed [19:0] accel_y;
    logic signed [19:0] accel_z;
    logic signed [19:0] gyro_x;
    logic signed [19:0] gyro_y;
    logic signed [19:0] gyro_z;
    logic               accel_ok;
    logic               gyro_ok;
    logic [2:0]         packet_status;
    logic               restart_request;

    packet_t  pkt_buf;
    int       pkt_count;
    logic     stream_synced;
    result_t  decoded_q[$];
    result_t  want_res;
    int       errors;
    int       words_sent;
    bit       tx_idle_on;
    bit       rx_idle_on;
    int       hold_request;
    int       stall_left;

    imu_fifo_packet_decoder_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .fifo_byte       (fifo_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .accel_x         (accel_x),
        .accel_y         (accel_y),
        .accel_z         (accel_z),
        .gyro_x          (gyro_x),
        .gyro_y          (gyro_y),
        .gyro_z          (gyro_z),
        .accel_ok        (accel_ok),
        .gyro_ok         (gyro_ok),
        .packet_status   (packet_status),
        .restart_request (restart_request)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic marker_at(input int start);
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            if (pkt_buf[start + i] != ((i % 2 == 0) ? MARKER_HIGH : MARKER_LOW))
                hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic result_t decode_packet();
        result_t    r;
        logic       a_ok;
        logic       g_ok;
        logic       is_empty;
        logic [19:0] av[3];
        logic [19:0] gv[3];
        r = '0;
        r.status = ST_SAMPLE;
        if (pkt_buf[0] == HDR_SAMPLE)
        begin
            a_ok = !marker_at(1);
            g_ok = !marker_at(7);
            stream_synced = 1'b1;
            if (!a_ok && !g_ok)
            begin
                r.status = ST_NO_VALID;
                return r;
            end
            for (int i = 0; i < 3; i++)
            begin
                av[i] = {pkt_buf[1 + 2 * i], pkt_buf[2 + 2 * i], pkt_buf[17 + i][7:4]};
                gv[i] = {pkt_buf[7 + 2 * i], pkt_buf[8 + 2 * i], pkt_buf[17 + i][3:0]};
                if (!a_ok)
                    av[i] = '0;
                if (!g_ok)
                    gv[i] = '0;
            end
            r.accel_x  = av[0];
            r.accel_y  = av[1];
            r.accel_z  = av[2];
            r.gyro_x   = gv[0];
            r.gyro_y   = gv[1];
            r.gyro_z   = gv[2];
            r.accel_ok = a_ok;
            r.gyro_ok  = g_ok;
            return r;
        end
        if (!stream_synced)
        begin
            r.status = ST_UNSYNCED;
            return r;
        end
        is_empty = 1'b1;
        for (int i = 0; i < PKT_LEN; i++)
        begin
            if (pkt_buf[i] != ((i < EMPTY_FILL_LEN) ? EMPTY_FILL : 8'h00))
                is_empty = 1'b0;
        end
        if (is_empty)
        begin
            r.status = ST_EMPTY;
            return r;
        end
        stream_synced = 1'b0;
        r.status  = ST_CORRUPT;
        r.restart = 1'b1;
        return r;
    endfunction

    function automatic void predict_word(input logic [7:0] b);
        pkt_buf[pkt_count] = b;
        pkt_count++;
        if (pkt_count == PKT_LEN)
        begin
            pkt_count = 0;
            decoded_q.push_back(decode_packet());
        end
    endfunction

    // Called and returning at a falling edge; valid stays high after the word is taken.
    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        fifo_byte = b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        predict_word(b);
        words_sent++;
    endtask

    task automatic send_packet(input packet_t p);
        for (int i = 0; i < PKT_LEN; i++)
            send_word(p[i]);
    endtask

    function automatic packet_t make_sample(input logic [19:0] a0, a1, a2, g0, g1, g2);
        packet_t     p;
        logic [19:0] av[3];
        logic [19:0] gv[3];
        av = '{a0, a1, a2};
        gv = '{g0, g1, g2};
        p[0] = HDR_SAMPLE;
        for (int i = 0; i < 3; i++)
        begin
            p[1 + 2 * i] = av[i][19:12];
            p[2 + 2 * i] = av[i][11:4];
            p[7 + 2 * i] = gv[i][19:12];
            p[8 + 2 * i] = gv[i][11:4];
            p[17 + i]    = {av[i][3:0], gv[i][3:0]};
        end
        for (int i = 13; i < 17; i++)
            p[i] = 8'($urandom_range(0, 255));
        return p;
    endfunction

    function automatic packet_t random_sample();
        return make_sample(20'($urandom), 20'($urandom), 20'($urandom),
                           20'($urandom), 20'($urandom), 20'($urandom));
    endfunction

    function automatic packet_t set_marker(input packet_t p, input int start);
        for (int i = 0; i < 6; i++)
            p[start + i] = (i % 2 == 0) ? MARKER_HIGH : MARKER_LOW;
        return p;
    endfunction

    function automatic packet_t empty_packet();
        packet_t p;
        for (int i = 0; i < PKT_LEN; i++)
            p[i] = (i < EMPTY_FILL_LEN) ? EMPTY_FILL : 8'h00;
        return p;
    endfunction

    function automatic packet_t random_packet();
        packet_t p;
        for (int i = 0; i < PKT_LEN; i++)
            p[i] = 8'($urandom_range(0, 255));
        return p;
    endfunction

    task automatic wait_drained();
        in_valid = 1'b0;
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic test_unsynced_headers();
        packet_t p;
        send_packet('0);
        for (int i = 0; i < PKT_LEN; i++)
            p[i] = 8'hFF;
        send_packet(p);
        send_packet(empty_packet());
        wait_drained();
    endtask

    task automatic test_sample_extremes();
        packet_t p;
        send_packet(make_sample(20'h7FFFF, 20'h80000, 20'hFFFFF, 20'h00000, 20'h00001, 20'h7FFFF));
        send_packet(make_sample(20'h00000, 20'hFFFFF, 20'h7FFFF, 20'h80000, 20'hA5A5A, 20'h5A5A5));
        p = set_marker(random_sample(), 1);
        p[6] = 8'h01;
        send_packet(p);
        wait_drained();
    endtask

    task automatic test_invalid_channels();
        send_packet(set_marker(random_sample(), 1));
        send_packet(set_marker(random_sample(), 7));
        send_packet(set_marker(set_marker(random_sample(), 1), 7));
        wait_drained();
    endtask

    task automatic test_empty_and_corruption();
        packet_t p;
        send_packet(random_sample());
        send_packet(empty_packet());
        p = empty_packet();
        p[12] = 8'h01;
        send_packet(p);
        send_packet(empty_packet());
        send_packet(random_sample());
        send_packet('0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle_on   = 1'b0;
        hold_request = 300;
        for (int i = 0; i < 5; i++)
            send_packet(random_sample());
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < 3; i++)
            send_packet(random_sample());
        wait_drained();
    endtask

    task automatic test_random_stream();
        packet_t p;
        int      kind;
        int      start_words;
        int      slip;
        start_words = words_sent;
        while (words_sent - start_words < 340)
        begin
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 55)
                p = random_sample();
            else if (kind < 62)
                p = set_marker(random_sample(), 1);
            else if (kind < 69)
                p = set_marker(random_sample(), 7);
            else if (kind < 73)
                p = set_marker(set_marker(random_sample(), 1), 7);
            else if (kind < 81)
                p = empty_packet();
            else if (kind < 86)
            begin
                p = empty_packet();
                slip = $urandom_range(1, PKT_LEN - 1);
                p[slip] = p[slip] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (kind < 96)
                p = random_packet();
            else
            begin
                slip = $urandom_range(1, PKT_LEN - 1);
                for (int i = 0; i < slip; i++)
                    send_word(8'($urandom_range(0, 255)));
                continue;
            end
            send_packet(p);
        end
        slip = PKT_LEN - pkt_count;
        if (slip < PKT_LEN)
            for (int i = 0; i < slip; i++)
                send_word(8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            out_ready  = 1'b0;
            stall_left = pick_gap() - 1;
        end
        else
            out_ready = 1'b1;
    end

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("result word with no packet pending");
                errors++;
            end
            else
            begin
                want_res = decoded_q.pop_front();
                check_field("accel_x", want_res.accel_x, accel_x);
                check_field("accel_y", want_res.accel_y, accel_y);
                check_field("accel_z", want_res.accel_z, accel_z);
                check_field("gyro_x", want_res.gyro_x, gyro_x);
                check_field("gyro_y", want_res.gyro_y, gyro_y);
                check_field("gyro_z", want_res.gyro_z, gyro_z);
                check_field("accel_ok", want_res.accel_ok, accel_ok);
                check_field("gyro_ok", want_res.gyro_ok, gyro_ok);
                check_field("packet_status", want_res.status, packet_status);
                check_field("restart_request", want_res.restart, restart_request);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        fifo_byte     = 8'h00;
        out_ready     = 1'b0;
        pkt_buf       = '0;
        pkt_count     = 0;
        stream_synced = 1'b0;
        errors        = 0;
        words_sent    = 0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        hold_request  = 0;
        stall_left    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_unsynced_headers();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_sample_extremes();
        test_invalid_channels();
        test_empty_and_corruption();
        test_backpressure();
        test_random_stream();

        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
